[rtl/assert_macros.svh]
// Assertion macros for the key matrix debounce reporter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define KMDR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define KMDR_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/kmdr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce reporter package
// Request and response types and the fixed constants of the report packet.
// ----------------------------------------------------------------------------
package kmdr_pkg;

   localparam int INPUT_ROWS = 6;
   localparam int INPUT_COLS = 7;
   localparam int CNT_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int SNAP_DEPTH = 2;

   localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 4'd5;
   localparam logic [BYTE_W-1:0] FRAME_START     = 8'hAA;
   localparam logic [BYTE_W-1:0] FRAME_END       = 8'h55;

   typedef struct packed {
      logic [INPUT_COLS-1:0] row5_keys;
      logic [INPUT_COLS-1:0] row4_keys;
      logic [INPUT_COLS-1:0] row3_keys;
      logic [INPUT_COLS-1:0] row2_keys;
      logic [INPUT_COLS-1:0] row1_keys;
      logic [INPUT_COLS-1:0] row0_keys;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packet_byte;
      logic              last_of_packet;
   } rsp_type;

endpackage

[rtl/kmdr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce front end
// Per-key integrating counters and debounced bits; queues a snapshot of the
// debounced matrix whenever a bit changes or no report has gone out yet.
// ----------------------------------------------------------------------------
module kmdr_front #(
   parameter int ROWS = 6,
   parameter int COLS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  kmdr_pkg::req_type                 req_data,
   input  logic                              csr_wr_en,
   input  logic [kmdr_pkg::CNT_W-1:0]        csr_wr_data,
   output logic                              snap_push,
   output logic [ROWS*COLS-1:0]              snap_data
);

   localparam int KEYS = ROWS * COLS;

   logic [kmdr_pkg::INPUT_ROWS-1:0][kmdr_pkg::INPUT_COLS-1:0] in_rows;
   logic [KEYS-1:0]                  raw;
   logic [kmdr_pkg::CNT_W-1:0]       thr_ff;
   logic [kmdr_pkg::CNT_W-1:0]       cnt_ff [KEYS];
   logic [kmdr_pkg::CNT_W-1:0]       cnt_in [KEYS];
   logic [KEYS-1:0]                  stable_ff;
   logic [KEYS-1:0]                  stable_in;
   logic [KEYS-1:0]                  key_chg;
   logic                             sent_once_ff;

   assign in_rows = {req_data.row5_keys, req_data.row4_keys, req_data.row3_keys,
                     req_data.row2_keys, req_data.row1_keys, req_data.row0_keys};

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar c = 0; c < COLS; c++) begin : g_col
         if (r < kmdr_pkg::INPUT_ROWS && c < kmdr_pkg::INPUT_COLS) begin : g_in
            assign raw[r*COLS+c] = in_rows[r][c];
         end else begin : g_none
            assign raw[r*COLS+c] = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KEYS; i++) begin
         cnt_in[i]    = cnt_ff[i];
         stable_in[i] = stable_ff[i];
         key_chg[i]   = 1'b0;
         if (accept) begin
            if (raw[i]) begin
               if (cnt_ff[i] < thr_ff) begin
                  cnt_in[i] = cnt_ff[i] + 4'd1;
               end
               if (cnt_in[i] == thr_ff && !stable_ff[i]) begin
                  stable_in[i] = 1'b1;
                  key_chg[i]   = 1'b1;
               end
            end else begin
               if (cnt_ff[i] != '0) begin
                  cnt_in[i] = cnt_ff[i] - 4'd1;
               end
               if (cnt_in[i] == '0 && stable_ff[i]) begin
                  stable_in[i] = 1'b0;
                  key_chg[i]   = 1'b1;
               end
            end
         end
      end
   end

   assign snap_push = accept && ((|key_chg) || !sent_once_ff);
   assign snap_data = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= kmdr_pkg::THRESHOLD_RESET;
         stable_ff    <= '0;
         sent_once_ff <= 1'b0;
         for (int i = 0; i < KEYS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         stable_ff <= stable_in;
         if (snap_push) begin
            sent_once_ff <= 1'b1;
         end
         for (int i = 0; i < KEYS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

endmodule

[rtl/kmdr_snap_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix snapshot queue
// Two-entry queue of debounced snapshots between front end and serialiser.
// ----------------------------------------------------------------------------
module kmdr_snap_fifo #(
   parameter int WIDTH = 42
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = $clog2(kmdr_pkg::SNAP_DEPTH);
   localparam int CNT_W = $clog2(kmdr_pkg::SNAP_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(kmdr_pkg::SNAP_DEPTH);

   logic [WIDTH-1:0] entry_ff [kmdr_pkg::SNAP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full     = (count_ff == DEPTH_C);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !(rd_en && rd_valid)) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!wr_en && rd_en && rd_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rd_en && rd_valid) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

[rtl/kmdr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix report serialiser
// Turns one snapshot into the framed packet: start, row bytes, XOR, end.
// ----------------------------------------------------------------------------
module kmdr_back #(
   parameter int ROWS = 6,
   parameter int COLS = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  snap_valid,
   input  logic [ROWS*COLS-1:0]  snap_data,
   output logic                  snap_pop,
   output logic                  empty,
   input  logic                  pop,
   output kmdr_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(ROWS + 3);
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [IDX_W-1:0] ROWS_IDX = IDX_W'(ROWS);
   localparam logic [IDX_W-1:0] SUM_IDX  = IDX_W'(ROWS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROWS + 2);

   logic [ROWS-1:0][COLS-1:0]       snap_ff;
   logic [ROWS-1:0][COLS-1:0]       snap_in;
   logic [IDX_W-1:0]                idx_ff;
   logic [IDX_W-1:0]                idx_in;
   logic [IDX_W-1:0]                idx_dec;
   logic [ROW_W-1:0]                row_sel;
   logic                            busy_ff;
   logic                            busy_in;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   kmdr_pkg::rsp_type               out_ff;
   kmdr_pkg::rsp_type               out_in;
   logic [kmdr_pkg::BYTE_W-1:0]     check;
   logic [kmdr_pkg::BYTE_W-1:0]     cur_byte;
   logic                            advance;

   assign idx_dec = idx_ff - IDX_W'(1);
   assign row_sel = idx_dec[ROW_W-1:0];
   assign advance = !out_valid_ff || pop;

   always_comb begin
      check = '0;
      for (int r = 0; r < ROWS; r++) begin
         check = check ^ kmdr_pkg::BYTE_W'(snap_ff[r]);
      end
   end

   always_comb begin
      priority if (idx_ff <= ROWS_IDX) begin
         cur_byte = kmdr_pkg::BYTE_W'(snap_ff[row_sel]);
      end else if (idx_ff == SUM_IDX) begin
         cur_byte = check;
      end else begin
         cur_byte = kmdr_pkg::FRAME_END;
      end
   end

   always_comb begin
      snap_in      = snap_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      snap_pop     = 1'b0;
      if (advance) begin
         if (busy_ff) begin
            out_valid_in          = 1'b1;
            out_in.packet_byte    = cur_byte;
            out_in.last_of_packet = (idx_ff == LAST_IDX);
            idx_in                = idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               busy_in = 1'b0;
            end
         end else if (snap_valid) begin
            snap_pop              = 1'b1;
            snap_in               = snap_data;
            idx_in                = IDX_W'(1);
            busy_in               = 1'b1;
            out_valid_in          = 1'b1;
            out_in.packet_byte    = kmdr_pkg::FRAME_START;
            out_in.last_of_packet = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      idx_ff  <= idx_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

endmodule

[rtl/key_matrix_debounce_reporter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce reporter
// Debounces a key matrix scan by scan and reports changes as framed packets.
// ----------------------------------------------------------------------------
// A reporting request is queued, then its start byte is registered.
// Throughput: one request per cycle while the two-entry snapshot queue has room;
// reports drain one byte per cycle while pop is high; packets hold ROWS+3 bytes.
// Reset: counters, debounced bits and queues clear; threshold returns to 5;
// the first request after reset always produces a packet.
module key_matrix_debounce_reporter_top #(
   parameter int ROWS = 6,
   parameter int COLS = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  kmdr_pkg::req_type           req_data,
   output logic                        empty,
   input  logic                        pop,
   output kmdr_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [kmdr_pkg::CNT_W-1:0]  csr_wr_data
);

   localparam int KEYS = ROWS * COLS;

   logic            accept;
   logic            snap_push;
   logic [KEYS-1:0] snap_wr_data;
   logic            snap_valid;
   logic [KEYS-1:0] snap_rd_data;
   logic            snap_pop;

   assign accept = push && !full;

   kmdr_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .snap_push   (snap_push),
      .snap_data   (snap_wr_data)
   );

   kmdr_snap_fifo #(.WIDTH(KEYS)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (snap_push),
      .wr_data  (snap_wr_data),
      .full     (full),
      .rd_en    (snap_pop),
      .rd_valid (snap_valid),
      .rd_data  (snap_rd_data)
   );

   kmdr_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_data  (snap_rd_data),
      .snap_pop   (snap_pop),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/kmdr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce reporter port checker
// Watches the top-level ports for packet framing and output ordering.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmdr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        empty,
   input logic                        pop,
   input kmdr_pkg::rsp_type           rsp_data
);

   logic shown;
   logic shown_last;
   logic end_byte;
   logic start_byte;
   logic popped_last;
   logic idle_or_start;
   logic stalled;

   assign shown         = !empty;
   assign shown_last    = shown && rsp_data.last_of_packet;
   assign end_byte      = (rsp_data.packet_byte == kmdr_pkg::FRAME_END);
   assign start_byte    = (rsp_data.packet_byte == kmdr_pkg::FRAME_START);
   assign popped_last   = shown_last && pop;
   assign idle_or_start = empty || start_byte;
   assign stalled       = shown && !pop;

   `KMDR_ASSERT_ALL(a_reset_empty, clock, reset |=> empty, "output not empty after reset")
   `KMDR_ASSERT(a_last_is_end, clock, reset, shown_last |-> end_byte, "last byte not end marker")
   `KMDR_ASSERT(a_start_follows, clock, reset, popped_last |=> idle_or_start, "bad packet start")
   `KMDR_ASSERT(a_hold, clock, reset, stalled |=> shown && $stable(rsp_data), "stall not held")

endmodule

bind key_matrix_debounce_reporter_top kmdr_checker u_kmdr_checker (.*);

[dv/key_matrix_debounce_reporter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix debounce reporter testbench
// Drives raw matrix scans through the request queue and predicts each report
// packet from a per-key integrating counter model. Every popped byte is
// checked against the oldest predicted byte. Threshold changes, including
// zero, fifteen and lowering below live counters, happen between idle phases.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module key_matrix_debounce_reporter_top_tb;

   localparam int KEYS       = kmdr_pkg::INPUT_ROWS * kmdr_pkg::INPUT_COLS;
   localparam int IDLE_LIMIT = 4000;
   localparam int RANDOM_SCANS = 220;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       push = 1'b0;
   logic                       full;
   kmdr_pkg::req_type          req_data = '0;
   logic                       empty;
   logic                       pop = 1'b0;
   kmdr_pkg::rsp_type          rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [kmdr_pkg::CNT_W-1:0] csr_wr_data = '0;

   key_matrix_debounce_reporter_top dut (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_data    (req_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // debounce state of the predictor
   logic [kmdr_pkg::CNT_W-1:0] key_level [KEYS];
   logic [KEYS-1:0]            key_down;
   logic                       report_sent;
   logic [kmdr_pkg::CNT_W-1:0] threshold;

   kmdr_pkg::req_type pending_scans [$];
   kmdr_pkg::rsp_type expected_bytes [$];

   bit          scan_taken;
   bit          steady;
   int unsigned scan_gap;
   int unsigned pop_gap;
   int unsigned idle_cycles;
   int unsigned mismatch_count;
   int unsigned scans_taken;
   int unsigned bytes_checked;
   int unsigned packets_checked;
   int unsigned random_scans;
   logic [15:0] thresholds_seen;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic void predict_report(kmdr_pkg::req_type scan);
      logic [KEYS-1:0]  raw;
      logic             changed;
      logic [7:0]       check;
      logic [7:0]       row_byte;
      kmdr_pkg::rsp_type word;
      raw = scan;
      changed = 1'b0;
      check = '0;
      for (int i = 0; i < KEYS; i++) begin
         if (raw[i]) begin
            if (key_level[i] < threshold) key_level[i] = key_level[i] + 1'b1;
            if (key_level[i] == threshold && !key_down[i]) begin
               key_down[i] = 1'b1;
               changed = 1'b1;
            end
         end else begin
            if (key_level[i] > 0) key_level[i] = key_level[i] - 1'b1;
            if (key_level[i] == 0 && key_down[i]) begin
               key_down[i] = 1'b0;
               changed = 1'b1;
            end
         end
      end
      if (!changed && report_sent) return;
      report_sent = 1'b1;
      word.packet_byte = kmdr_pkg::FRAME_START;
      word.last_of_packet = 1'b0;
      expected_bytes.push_back(word);
      for (int r = 0; r < kmdr_pkg::INPUT_ROWS; r++) begin
         row_byte = {1'b0, key_down[r*kmdr_pkg::INPUT_COLS +: kmdr_pkg::INPUT_COLS]};
         check = check ^ row_byte;
         word.packet_byte = row_byte;
         expected_bytes.push_back(word);
      end
      word.packet_byte = check;
      expected_bytes.push_back(word);
      word.packet_byte = kmdr_pkg::FRAME_END;
      word.last_of_packet = 1'b1;
      expected_bytes.push_back(word);
   endfunction

   // request side: hold until taken, then idle for the chosen gap
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
         scan_gap <= 0;
      end else if (push && !scan_taken) begin
      end else if (scan_gap != 0) begin
         push <= 1'b0;
         scan_gap <= scan_gap - 1;
      end else if (pending_scans.size() != 0) begin
         req_data <= pending_scans.pop_front();
         push <= 1'b1;
         scan_gap <= pick_gap();
      end else begin
         push <= 1'b0;
      end
   end

   // response side: stall at random
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_gap <= 0;
      end else if (pop_gap != 0) begin
         pop <= 1'b0;
         pop_gap <= pop_gap - 1;
      end else begin
         pop <= 1'b1;
         if ($urandom_range(0, 2) == 0) pop_gap <= pick_gap();
      end
   end

   always @(posedge clock) begin
      logic              progress;
      kmdr_pkg::rsp_type want;
      progress = 1'b0;
      scan_taken = 1'b0;
      if (reset) begin
         for (int i = 0; i < KEYS; i++) key_level[i] = '0;
         key_down = '0;
         report_sent = 1'b0;
         threshold = kmdr_pkg::THRESHOLD_RESET;
         idle_cycles = 0;
      end else begin
         if (csr_wr_en) begin
            threshold = csr_wr_data;
            progress = 1'b1;
         end
         if (pop && !empty) begin
            progress = 1'b1;
            if (expected_bytes.size() == 0) begin
               $error("unexpected report byte %h last %b",
                      rsp_data.packet_byte, rsp_data.last_of_packet);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.packet_byte !== want.packet_byte) begin
                  $error("packet_byte: expected %h, actual %h",
                         want.packet_byte, rsp_data.packet_byte);
                  mismatch_count++;
               end
               if (rsp_data.last_of_packet !== want.last_of_packet) begin
                  $error("last_of_packet: expected %b, actual %b",
                         want.last_of_packet, rsp_data.last_of_packet);
                  mismatch_count++;
               end
               bytes_checked++;
               if (want.last_of_packet) packets_checked++;
            end
         end
         if (push && !full) begin
            predict_report(req_data);
            scan_taken = 1'b1;
            scans_taken++;
            progress = 1'b1;
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("key_matrix_debounce_reporter_top: mismatch");
               $finish;
            end
         end
      end
   end

   task automatic queue_scan(input logic [KEYS-1:0] bits, input int unsigned count);
      for (int n = 0; n < count; n++) pending_scans.push_back(kmdr_pkg::req_type'(bits));
   endtask

   task automatic drain();
      while (pending_scans.size() != 0 || push || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_threshold(input logic [kmdr_pkg::CNT_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      thresholds_seen[value] = 1'b1;
   endtask

   function automatic logic [KEYS-1:0] random_pattern();
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return a[KEYS-1:0] & b[KEYS-1:0] & c[KEYS-1:0];
         1: return a[KEYS-1:0];
         2: return {{(KEYS-1){1'b0}}, 1'b1} << $urandom_range(0, KEYS-1);
         3: return '1;
         default: return a[KEYS-1:0] & b[KEYS-1:0];
      endcase
   endfunction

   // one burst of scans: a held pattern with bounce, a release, or noise
   task automatic queue_segment(input int unsigned thr);
      logic [KEYS-1:0] pattern;
      logic [KEYS-1:0] scan;
      int unsigned     len;
      int unsigned     mode;
      mode = $urandom_range(0, 9);
      pattern = (mode < 6) ? random_pattern() : '0;
      if (mode == 7) pattern = random_pattern() & random_pattern();
      len = thr + $urandom_range(0, 3);
      if (len == 0) len = 1;
      if (mode >= 8) len = $urandom_range(1, 4);
      for (int n = 0; n < len; n++) begin
         scan = (mode >= 8) ? random_pattern() : pattern;
         if (mode < 8 && $urandom_range(0, 3) == 0)
            scan[$urandom_range(0, KEYS-1)] ^= 1'b1;
         pending_scans.push_back(kmdr_pkg::req_type'(scan));
         random_scans++;
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned thr;
      int unsigned target;
      mismatch_count = 0;
      scans_taken = 0;
      bytes_checked = 0;
      packets_checked = 0;
      random_scans = 0;
      thresholds_seen = '0;
      thresholds_seen[kmdr_pkg::THRESHOLD_RESET] = 1'b1;
      steady = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // first scan always reports; press everything, then release everything
      queue_scan('0, 1);
      queue_scan('1, 5);
      queue_scan('0, 5);
      drain();

      // zero threshold follows the raw scan; a repeated scan reports nothing
      set_threshold(4'd0);
      queue_scan({21{2'b01}}, 1);
      queue_scan({21{2'b10}}, 2);
      queue_scan('0, 1);
      drain();

      // lower the threshold below live counters
      set_threshold(4'd2);
      queue_scan('1, 2);
      drain();
      set_threshold(4'd1);
      queue_scan('1, 1);
      queue_scan('0, 2);
      drain();

      phase = 0;
      while (random_scans < RANDOM_SCANS) begin
         case (phase)
            0: thr = 15;
            1: thr = 1;
            2: thr = 0;
            3: thr = 9;
            4: thr = 3;
            5: thr = 12;
            6: thr = 5;
            7: thr = 2;
            default: thr = $urandom_range(0, 15);
         endcase
         set_threshold(thr[kmdr_pkg::CNT_W-1:0]);
         steady = ($urandom_range(0, 3) == 0);
         target = random_scans + 35;
         while (random_scans < target) queue_segment(thr);
         drain();
         phase++;
      end
      repeat (10) @(negedge clock);

      $display("%0d scans taken, %0d report bytes checked in %0d packets",
               scans_taken, bytes_checked, packets_checked);
      $display("%0d distinct threshold settings used, 0 and 15 among them",
               $countones(thresholds_seen));
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("key_matrix_debounce_reporter_top: match");
      end else begin
         $display("key_matrix_debounce_reporter_top: mismatch");
      end
      $finish;
   end

endmodule
